>>> sv/modular_dot_product_karatsuba_core_defines.svh
// assertion macros shared by the modular dot product core
// depends on nothing; included by the modules that carry checks
`ifndef MODULAR_DOT_PRODUCT_KARATSUBA_CORE_DEFINES_SVH
`define MODULAR_DOT_PRODUCT_KARATSUBA_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// condition must never hold outside reset
`define MDK_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define MDK_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MDK_ASSERT_NEVER(lbl, clk, rst, cond)
`define MDK_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif

`endif

>>> sv/mdk_pkg.sv
// shared types and constants of the modular dot product core
// depends on nothing
package mdk_pkg;

  localparam int BLOCK_LEN   = 256;
  localparam int LIMB_BITS   = 27;
  localparam int CNT_W       = $clog2(BLOCK_LEN + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_POW32   = 2'd1;
  localparam logic [1:0] REG_POW27   = 2'd2;
  localparam logic [1:0] REG_POW54   = 2'd3;

  // one multiplied item between front and back
  typedef struct packed {
    logic [63:0] p_low;
    logic [63:0] p_mid;
    logic [63:0] p_high;
    logic [51:0] init;
    logic        first;
    logic        last;
  } item_t;

  // request to the modular multiply unit
  typedef struct packed {
    logic        start;
    logic [52:0] x;
    logic [52:0] y;
  } mm_req_t;

  // response of the modular multiply unit
  typedef struct packed {
    logic        done;
    logic [52:0] r;
  } mm_rsp_t;

endpackage

>>> sv/mdk_front.sv
// front: takes factor beats, lifts and splits them, forms the three partial products
// depends on mdk_pkg
module mdk_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [51:0]    a_value,
  input  logic [51:0]    b_value,
  input  logic [51:0]    init_value,
  input  logic           first,
  input  logic           last,
  input  logic [52:0]    n,
  input  logic           q_full,
  output logic           q_push,
  output mdk_pkg::item_t q_item
);

  // lift to the symmetric range
  function automatic logic [53:0] lift(input logic [51:0] a, input logic [52:0] m);
    logic [53:0] s;
    if ({1'b0, a} > (m >> 1)) s = {2'b00, a} - {1'b0, m};
    else s = {2'b00, a};
    return s;
  endfunction

  logic        adv;
  logic        s1_valid;
  logic [51:0] s1_a, s1_b, s1_init;
  logic        s1_first, s1_last;
  logic        s2_valid;
  logic signed [26:0] s2_a0, s2_a1, s2_b0, s2_b1;
  logic [51:0] s2_init;
  logic        s2_first, s2_last;
  logic        s3_valid;
  mdk_pkg::item_t s3_item;

  logic [53:0] sa, sb;
  logic signed [26:0] a0, a1, b0, b1;
  logic signed [27:0] am, bm;
  logic signed [53:0] pl, ph;
  logic signed [55:0] pm;

  // pipeline advances unless the last stage is blocked
  assign adv = !(s3_valid && q_full);
  assign in_stall = !adv;
  assign q_push = s3_valid && !q_full;
  assign q_item = s3_item;

  // limb split
  always_comb begin
    sa = lift(s1_a, n);
    sb = lift(s1_b, n);
    a0 = sa[26:0];
    b0 = sb[26:0];
    a1 = sa[53:27] + {26'b0, sa[26]};
    b1 = sb[53:27] + {26'b0, sb[26]};
  end

  // partial products
  always_comb begin
    am = {s2_a0[26], s2_a0} + {s2_a1[26], s2_a1};
    bm = {s2_b0[26], s2_b0} + {s2_b1[26], s2_b1};
    pl = s2_a0 * s2_b0;
    ph = s2_a1 * s2_b1;
    pm = am * bm;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a     <= a_value;
      s1_b     <= b_value;
      s1_init  <= init_value;
      s1_first <= first;
      s1_last  <= last;
      s2_a0    <= a0;
      s2_a1    <= a1;
      s2_b0    <= b0;
      s2_b1    <= b1;
      s2_init  <= s1_init;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s3_item.p_low  <= {{10{pl[53]}}, pl};
      s3_item.p_mid  <= {{8{pm[55]}}, pm};
      s3_item.p_high <= {{10{ph[53]}}, ph};
      s3_item.init   <= s2_init;
      s3_item.first  <= s2_first;
      s3_item.last   <= s2_last;
    end
  end

endmodule

>>> sv/mdk_queue.sv
// short queue of product beats between front and back
// depends on mdk_pkg and the assertion macro header
`include "modular_dot_product_karatsuba_core_defines.svh"
module mdk_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mdk_pkg::item_t push_item,
  input  logic           pop,
  output mdk_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);

  mdk_pkg::item_t mem [mdk_pkg::QUEUE_DEPTH];
  logic [mdk_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [mdk_pkg::QPTR_W:0]   count;

  assign full  = (count == (mdk_pkg::QPTR_W + 1)'(mdk_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_item = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `MDK_ASSERT_NEVER(a_queue_level, clk, rst, count > (mdk_pkg::QPTR_W + 1)'(mdk_pkg::QUEUE_DEPTH))

endmodule

>>> sv/mdk_mulmod.sv
// bit-serial modular multiply, one bit of y per cycle, x below n
// depends on mdk_pkg and the assertion macro header
`include "modular_dot_product_karatsuba_core_defines.svh"
module mdk_mulmod (
  input  logic             clk,
  input  logic             rst,
  input  mdk_pkg::mm_req_t req,
  input  logic [52:0]      n,
  output mdk_pkg::mm_rsp_t rsp
);

  logic        busy, done;
  logic [5:0]  bit_idx;
  logic [52:0] x, y, nr, r;
  logic [53:0] r_sh, r_a, r_b, r_c;
  logic [52:0] r_new;

  // double, then add x when the bit is set, reducing after each
  always_comb begin
    r_sh = {r, 1'b0};
    r_a  = (r_sh >= {1'b0, nr}) ? r_sh - {1'b0, nr} : r_sh;
    r_b  = r_a + {1'b0, x};
    r_c  = (r_b >= {1'b0, nr}) ? r_b - {1'b0, nr} : r_b;
    r_new = y[bit_idx] ? r_c[52:0] : r_a[52:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      r    <= '0;
    end else begin
      done <= busy && (bit_idx == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        r    <= '0;
      end else if (busy) begin
        r <= r_new;
        if (bit_idx == 6'd0) busy <= 1'b0;
      end
    end
  end

  // operands and bit counter
  always_ff @(posedge clk) begin
    if (req.start) begin
      x       <= req.x;
      y       <= req.y;
      nr      <= n;
      bit_idx <= 6'd52;
    end else if (busy) begin
      bit_idx <= bit_idx - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.r    = r;

  `MDK_ASSERT_IMPLIES(a_mm_reduced, clk, rst, busy, r < nr)

endmodule

>>> sv/mdk_back.sv
// back: accumulates the three sums and folds or closes them through the mulmod unit
// depends on mdk_pkg, mdk_mulmod and the assertion macro header
`include "modular_dot_product_karatsuba_core_defines.svh"
module mdk_back (
  input  logic           clk,
  input  logic           rst,
  input  mdk_pkg::item_t q_item,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic [52:0]    n,
  input  logic [51:0]    pow32_residue,
  input  logic [51:0]    pow27_residue,
  input  logic [51:0]    pow54_residue,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [51:0]    residue
);

  localparam logic [1:0] ST_ACC   = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [3:0] OP_P32  = 4'd0;
  localparam logic [3:0] OP_P27  = 4'd1;
  localparam logic [3:0] OP_P54  = 4'd2;
  localparam logic [3:0] OP_HI0  = 4'd3;
  localparam logic [3:0] OP_LO0  = 4'd4;
  localparam logic [3:0] OP_HI1  = 4'd5;
  localparam logic [3:0] OP_LO1  = 4'd6;
  localparam logic [3:0] OP_HI2  = 4'd7;
  localparam logic [3:0] OP_LO2  = 4'd8;
  localparam logic [3:0] OP_MID  = 4'd9;
  localparam logic [3:0] OP_HIGH = 4'd10;

  function automatic logic [51:0] mod_add(input logic [51:0] a, input logic [51:0] b,
                                          input logic [52:0] m);
    logic [53:0] s;
    s = {2'b00, a} + {2'b00, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[51:0];
  endfunction

  logic [1:0]  state;
  logic [3:0]  op;
  logic        closing;
  logic [63:0] acc_low, acc_mid, acc_high, diff;
  logic [mdk_pkg::CNT_W-1:0] count;
  logic [51:0] p32r, p27r, p54r, t, r0, r1, r2, v, fin;

  logic [63:0] base_low, base_mid, base_high, low_n, mid_n, high_n;
  logic [mdk_pkg::CNT_W-1:0] cnt_n;
  logic        trigger;
  logic [63:0] sel_sum;
  logic [32:0] mag;
  logic [52:0] one;
  logic [51:0] res, t_new;
  logic        out_free;
  mdk_pkg::mm_req_t mm_req;
  mdk_pkg::mm_rsp_t mm_rsp;

  mdk_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .n   (n),
    .rsp (mm_rsp)
  );

  assign q_pop    = (state == ST_ACC) && !q_empty;
  assign out_free = !out_valid || !out_stall;
  assign one      = (n == 53'd1) ? 53'd0 : 53'd1;
  assign res      = mm_rsp.r[51:0];

  // accumulate step
  always_comb begin
    base_low  = q_item.first ? {12'b0, q_item.init} : acc_low;
    base_mid  = q_item.first ? {12'b0, q_item.init} : acc_mid;
    base_high = q_item.first ? 64'd0 : acc_high;
    low_n     = base_low + q_item.p_low;
    mid_n     = base_mid + q_item.p_mid;
    high_n    = base_high + q_item.p_high;
    cnt_n     = (q_item.first ? '0 : count) + 1'b1;
    trigger   = q_item.last || (cnt_n == mdk_pkg::CNT_W'(mdk_pkg::BLOCK_LEN));
  end

  // sum under reduction and its 2^32 magnitude word
  always_comb begin
    unique case (op)
      OP_HI0, OP_LO0: sel_sum = acc_low;
      OP_HI1, OP_LO1: sel_sum = diff;
      default:        sel_sum = acc_high;
    endcase
    if (sel_sum[63]) mag = 33'h1_0000_0000 - {1'b0, sel_sum[63:32]};
    else mag = {1'b0, sel_sum[63:32]};
    if (!sel_sum[63] || (res == 52'd0)) t_new = res;
    else t_new = 52'(n - {1'b0, res});
  end

  // operand select for the mulmod unit
  always_comb begin
    mm_req.start = (state == ST_ISSUE);
    unique case (op)
      OP_P32:                 begin mm_req.x = one; mm_req.y = {1'b0, pow32_residue}; end
      OP_P27:                 begin mm_req.x = one; mm_req.y = {1'b0, pow27_residue}; end
      OP_P54:                 begin mm_req.x = one; mm_req.y = {1'b0, pow54_residue}; end
      OP_HI0, OP_HI1, OP_HI2: begin mm_req.x = {1'b0, p32r}; mm_req.y = {20'b0, mag}; end
      OP_LO0, OP_LO1, OP_LO2: begin mm_req.x = one; mm_req.y = {21'b0, sel_sum[31:0]}; end
      OP_MID:                 begin mm_req.x = {1'b0, p27r}; mm_req.y = {1'b0, r1}; end
      OP_HIGH:                begin mm_req.x = {1'b0, p54r}; mm_req.y = {1'b0, r2}; end
      default:                begin mm_req.x = one; mm_req.y = '0; end
    endcase
  end

  // control and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      acc_low   <= '0;
      acc_mid   <= '0;
      acc_high  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // result beat taken, unless a new one is loaded in the same cycle
      if (out_valid && !out_stall && !(state == ST_EMIT && closing)) out_valid <= 1'b0;
      unique case (state)
        ST_ACC: begin
          if (q_pop) begin
            acc_low  <= low_n;
            acc_mid  <= mid_n;
            acc_high <= high_n;
            count    <= cnt_n;
            if (trigger) state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (mm_rsp.done) begin
            if (op == OP_HIGH) state <= ST_EMIT;
            else state <= ST_ISSUE;
          end
        end
        ST_EMIT: begin
          if (!closing) begin
            acc_low  <= {12'b0, fin};
            acc_mid  <= {12'b0, fin};
            acc_high <= '0;
            count    <= '0;
            state    <= ST_ACC;
          end else if (out_free) begin
            out_valid <= 1'b1;
            acc_low   <= '0;
            acc_mid   <= '0;
            acc_high  <= '0;
            count     <= '0;
            state     <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  // reduction sequence data
  always_ff @(posedge clk) begin
    if (state == ST_ACC && q_pop && trigger) begin
      op      <= OP_P32;
      closing <= q_item.last;
      diff    <= mid_n - low_n - high_n;
    end
    if (state == ST_WAIT && mm_rsp.done) begin
      op <= op + 1'b1;
      unique case (op)
        OP_P32:                 p32r <= res;
        OP_P27:                 p27r <= res;
        OP_P54:                 p54r <= res;
        OP_HI0, OP_HI1, OP_HI2: t <= t_new;
        OP_LO0:                 r0 <= mod_add(t, res, n);
        OP_LO1:                 r1 <= mod_add(t, res, n);
        OP_LO2:                 r2 <= mod_add(t, res, n);
        OP_MID:                 v <= mod_add(r0, res, n);
        OP_HIGH:                fin <= mod_add(v, res, n);
        default:                v <= v;
      endcase
    end
    if (state == ST_EMIT && closing && out_free) residue <= fin;
  end

  `MDK_ASSERT_IMPLIES(a_count_bound, clk, rst, state == ST_ACC, count < mdk_pkg::CNT_W'(mdk_pkg::BLOCK_LEN))
  `MDK_ASSERT_IMPLIES(a_out_reduced, clk, rst, out_valid, {1'b0, residue} < n)

endmodule

>>> sv/modular_dot_product_karatsuba_core.sv
// path: 3 front stages, the queue, the accumulate step, then the reduction in eleven
// passes of the bit-serial mulmod unit before the result beat
// throughput: one item per cycle between reductions; each fold after BLOCK_LEN items
// and each closing item hold the back for the reduction, the front then fills the queue
// reset: synchronous active-high rst clears sums, count, queue and valids;
// modulus resets to 1 and the residue registers to 0
module modular_dot_product_karatsuba_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [52:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [51:0] a_value,
  input  logic [51:0] b_value,
  input  logic [51:0] init_value,
  input  logic        first,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [51:0] residue
);

  logic [52:0] modulus;
  logic [51:0] pow32_residue, pow27_residue, pow54_residue;
  logic [52:0] eff_n;
  logic        q_push, q_pop, q_full, q_empty;
  mdk_pkg::item_t push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= 53'd1;
      pow32_residue <= '0;
      pow27_residue <= '0;
      pow54_residue <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdk_pkg::REG_MODULUS: modulus       <= cfg_data;
        mdk_pkg::REG_POW32:   pow32_residue <= cfg_data[51:0];
        mdk_pkg::REG_POW27:   pow27_residue <= cfg_data[51:0];
        mdk_pkg::REG_POW54:   pow54_residue <= cfg_data[51:0];
        default:              modulus       <= modulus;
      endcase
    end
  end

  // zero modulus acts as one
  assign eff_n = (modulus == '0) ? 53'd1 : modulus;

  mdk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .a_value    (a_value),
    .b_value    (b_value),
    .init_value (init_value),
    .first      (first),
    .last       (last),
    .n          (eff_n),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  mdk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  mdk_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_item        (pop_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .n             (eff_n),
    .pow32_residue (pow32_residue),
    .pow27_residue (pow27_residue),
    .pow54_residue (pow54_residue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .residue       (residue)
  );

endmodule

>>> sim/mdk_residue_checker.sv
// watches the config port and both channels of the modular dot product core,
// predicts each closing residue and compares it; depends on mdk_pkg
module mdk_residue_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [52:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [51:0] a_value,
  input  logic [51:0] b_value,
  input  logic [51:0] init_value,
  input  logic        first,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [51:0] residue,
  output int          errors,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the config registers
  logic [52:0] mod_reg;
  logic [51:0] p32_reg, p27_reg, p54_reg;

  // shadow of the three karatsuba sums and the block count
  logic [63:0] sum_low, sum_mid, sum_high;
  int          block_count;

  logic [51:0] expected_residues[$];

  // x * y mod n, bit serial, for x, y < n <= 2^52
  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] r;
    r = 0;
    for (int i = 52; i >= 0; i--) begin
      r = r << 1;
      if (r >= n) r = r - n;
      if (y[i]) begin
        r = r + x;
        if (r >= n) r = r - n;
      end
    end
    return r;
  endfunction

  // residue of a signed 64-bit sum through its 32-bit halves
  function automatic logic [63:0] sum_residue(logic [63:0] x, logic [63:0] n);
    logic [63:0] lo, hi, mag, t;
    lo  = {32'd0, x[31:0]};
    hi  = x >> 32;
    mag = x[63] ? ((64'd1 << 32) - hi) : hi;
    t   = mulmod(mag % n, {12'd0, p32_reg} % n, n);
    if (x[63]) t = (n - t) % n;
    t = t + (lo % n);
    if (t >= n) t = t - n;
    return t;
  endfunction

  // low + 2^27*(mid-low-high) + 2^54*high mod n
  function automatic logic [63:0] sums_residue(logic [63:0] n);
    logic [63:0] v;
    v = sum_residue(sum_low, n);
    v = v + mulmod(sum_residue(sum_mid - sum_low - sum_high, n), {12'd0, p27_reg} % n, n);
    if (v >= n) v = v - n;
    v = v + mulmod(sum_residue(sum_high, n), {12'd0, p54_reg} % n, n);
    if (v >= n) v = v - n;
    return v;
  endfunction

  // symmetric lift and signed two-limb split
  function automatic void limb_split(logic [63:0] a, logic [63:0] n,
                                     output longint lo, output longint hi);
    longint s, half, mask;
    half = longint'(1) << (mdk_pkg::LIMB_BITS - 1);
    mask = (longint'(1) << mdk_pkg::LIMB_BITS) - 1;
    s  = (a > n / 2) ? longint'(a) - longint'(n) : longint'(a);
    lo = ((s + half) & mask) - half;
    hi = (s - lo) >>> mdk_pkg::LIMB_BITS;
  endfunction

  // one accepted beat into the sums
  task automatic accumulate_beat();
    logic [63:0] n, r;
    longint a0, a1, b0, b1;
    n = (mod_reg == '0) ? 64'd1 : {11'd0, mod_reg};
    if (first) begin
      sum_low = {12'd0, init_value};
      sum_mid = {12'd0, init_value};
      sum_high = '0;
      block_count = 0;
    end
    limb_split({12'd0, a_value}, n, a0, a1);
    limb_split({12'd0, b_value}, n, b0, b1);
    sum_low  = sum_low + a0 * b0;
    sum_mid  = sum_mid + (a0 + a1) * (b0 + b1);
    sum_high = sum_high + a1 * b1;
    block_count++;
    if (last) begin
      r = sums_residue(n);
      expected_residues.push_back(r[51:0]);
      sum_low = '0;
      sum_mid = '0;
      sum_high = '0;
      block_count = 0;
    end else if (block_count >= mdk_pkg::BLOCK_LEN) begin
      r = sums_residue(n);
      sum_low = r;
      sum_mid = r;
      sum_high = '0;
      block_count = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mod_reg = 53'd1;
      p32_reg = '0;
      p27_reg = '0;
      p54_reg = '0;
      sum_low = '0;
      sum_mid = '0;
      sum_high = '0;
      block_count = 0;
      expected_residues.delete();
      errors = 0;
      checked = 0;
    end else begin
      // config write
      if (cfg_we) begin
        case (cfg_index)
          mdk_pkg::REG_MODULUS: mod_reg = cfg_data;
          mdk_pkg::REG_POW32:   p32_reg = cfg_data[51:0];
          mdk_pkg::REG_POW27:   p27_reg = cfg_data[51:0];
          mdk_pkg::REG_POW54:   p54_reg = cfg_data[51:0];
          default: ;
        endcase
      end
      // result beat against oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_residues.size() == 0) begin
          $error("residue beat with nothing expected: got %0h", residue);
          errors++;
        end else begin
          if (residue !== expected_residues[0]) begin
            $error("residue mismatch: expected %0h actual %0h", expected_residues[0], residue);
            errors++;
          end
          void'(expected_residues.pop_front());
          checked++;
        end
      end
      // input beat
      if (in_valid && !in_stall) accumulate_beat();
    end
    pending = expected_residues.size();
  end
endmodule

>>> sim/testbench.sv
// stimulus and verdict for the modular dot product core; the residue checker
// beside the block does all prediction; depends on mdk_pkg and the core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = mdk_pkg::REG_MODULUS;
  logic [52:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [51:0] a_value = '0, b_value = '0, init_value = '0;
  logic        first = 1'b0, last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [51:0] residue;

  int          errors, pending, checked;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  int          out_hold = 0;
  bit          quiet = 0;
  logic [63:0] cur_mod = 1;

  always #5 clk = ~clk;

  modular_dot_product_karatsuba_core uut (.*);

  mdk_residue_checker chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .a_value, .b_value, .init_value, .first, .last, .out_valid, .out_stall,
    .residue, .errors, .pending, .checked
  );

  // result side stall bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_hold = 0;
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= (out_hold > 0);
    end else if ($urandom_range(0, 5) == 0) begin
      out_hold = $urandom_range(1, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted beat or config write
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [51:0] rand52();
    return 52'({$urandom(), $urandom()});
  endfunction

  // factor: mostly canonical, sometimes raw or at the edges
  function automatic logic [51:0] pick_factor();
    case ($urandom_range(0, 9))
      0: return rand52();
      1: return 52'(cur_mod - 1);
      2: return 52'(cur_mod / 2);
      3: return 52'(cur_mod / 2 + 1);
      default: return 52'({12'd0, rand52()} % cur_mod);
    endcase
  endfunction

  // write all four registers back to back
  task automatic write_regs(logic [52:0] n, logic [51:0] p32, logic [51:0] p27, logic [51:0] p54);
    cur_mod = (n == '0) ? 64'd1 : {11'd0, n};
    cfg_we <= 1'b1;
    cfg_index <= mdk_pkg::REG_MODULUS; cfg_data <= n;            @(posedge clk);
    cfg_index <= mdk_pkg::REG_POW32;   cfg_data <= {1'b0, p32};  @(posedge clk);
    cfg_index <= mdk_pkg::REG_POW27;   cfg_data <= {1'b0, p27};  @(posedge clk);
    cfg_index <= mdk_pkg::REG_POW54;   cfg_data <= {1'b0, p54};  @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_true_regs(logic [52:0] n);
    write_regs(n, 52'((64'd1 << 32) % n), 52'((64'd1 << 27) % n), 52'((64'd1 << 54) % n));
  endtask

  // one input beat, with an optional gap ahead of it
  task automatic send_beat(logic [51:0] a, logic [51:0] b, logic [51:0] init,
                           logic f, logic l);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    a_value <= a; b_value <= b; init_value <= init; first <= f; last <= l;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // wait for every residue, then let a fold in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one well formed sum of len products
  task automatic send_sum(int len);
    logic [51:0] init;
    init = ($urandom_range(0, 7) == 0) ? rand52() : 52'({12'd0, rand52()} % cur_mod);
    for (int i = 0; i < len; i++)
      send_beat(pick_factor(), pick_factor(), init, i == 0, i == len - 1);
  endtask

  // random sums mixed with noise beats
  task automatic random_beats(int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(rand52(), rand52(), rand52(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        send_sum(len);
        sent += len;
      end
    end
  endtask

  initial begin
    logic [52:0] n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // modulus zero acts as one
    write_regs(53'd0, 52'd0, 52'd0, 52'd0);
    send_beat(rand52(), rand52(), rand52(), 1'b1, 1'b0);
    send_beat(52'hF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 52'd0, 1'b0, 1'b1);
    settle();

    // largest modulus, directed edges
    write_true_regs(53'h10_0000_0000_0000);
    send_beat(52'd0, 52'd0, 52'd0, 1'b1, 1'b1);
    send_beat(52'(cur_mod - 1), 52'(cur_mod - 1), 52'(cur_mod - 1), 1'b1, 1'b1);
    send_beat(52'(cur_mod / 2), 52'(cur_mod / 2), 52'd0, 1'b1, 1'b0);
    send_beat(52'(cur_mod / 2 + 1), 52'(cur_mod / 2 + 1), 52'd0, 1'b0, 1'b0);
    send_beat(52'(cur_mod / 2), 52'(cur_mod / 2 + 1), 52'd0, 1'b0, 1'b1);
    send_beat(52'h3FF_FFFF, 52'h400_0000, 52'd0, 1'b0, 1'b1);
    send_beat(52'h5_5555_5555_5555, 52'hA_AAAA_AAAA_AAAA, 52'hA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    send_beat(52'hA_AAAA_AAAA_AAAA, 52'h5_5555_5555_5555, 52'd0, 1'b0, 1'b0);
    send_beat(52'(cur_mod - 1), 52'd1, 52'd0, 1'b0, 1'b1);
    send_beat(52'd1, 52'(cur_mod - 1), 52'd5, 1'b1, 1'b0);
    send_beat(52'd7, 52'd9, 52'hF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_beat(52'(cur_mod - 2), 52'(cur_mod - 3), 52'd0, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) send_beat(pick_factor(), pick_factor(), rand52(), i == 0, i == 5);
    settle();

    // random large modulus, one sum long enough to fold, then random sums
    n = {1'b0, 1'b1, 51'(rand52())} | 53'd1;
    write_true_regs(n);
    send_sum(mdk_pkg::BLOCK_LEN + 5);
    random_beats(80);
    settle();

    // small modulus with unreduced weight registers
    write_regs(53'($urandom_range(2, 1000)), 52'hF_FFFF_FFFF_FFFF,
               52'hF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF);
    random_beats(30);
    settle();

    // mid modulus, final stretch without idling
    n = 53'(rand52() >> $urandom_range(0, 40)) | 53'd3;
    write_true_regs(n);
    random_beats(40);
    quiet = 1;
    random_beats(30);
    settle();

    $display("covered %0d input beats and %0d residues over five register settings,",
             beats_sent, checked);
    $display("including modulus zero, the largest modulus, a block fold and noise beats");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/mdk_pkg.sv
sv/mdk_front.sv
sv/mdk_queue.sv
sv/mdk_mulmod.sv
sv/mdk_back.sv
sv/modular_dot_product_karatsuba_core.sv
sim/mdk_residue_checker.sv
sim/testbench.sv
